FILE: sv/acp_pkg.sv
// ============================================================================
// acp_pkg
// Shared types and constants for the box collision push-out core.
// ============================================================================
package acp_pkg;

    localparam int CW = 32;
    localparam int DW = CW + 2;

    localparam logic [CW-1:0] HEAD_CLEAR = CW'(13107);

    typedef enum logic [0:0] {
        CMD_WRITE   = 1'b0,
        CMD_RESOLVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_EYE    = 2'd1,
        REG_ACTIVE = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } vec_t;

    typedef struct packed {
        vec_t mn;
        vec_t mx;
    } box_t;

    // Saturating signed add of two coordinates.
    function automatic logic [CW-1:0] sadd(input logic [CW-1:0] a,
                                           input logic [CW-1:0] b);
        logic signed [CW:0] s;
        s = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
        if (s[CW] != s[CW-1]) return s[CW] ? {1'b1, {(CW-1){1'b0}}}
                                           : {1'b0, {(CW-1){1'b1}}};
        return s[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] ssub(input logic [CW-1:0] a,
                                           input logic [CW-1:0] b);
        logic signed [CW:0] s;
        s = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        if (s[CW] != s[CW-1]) return s[CW] ? {1'b1, {(CW-1){1'b0}}}
                                           : {1'b0, {(CW-1){1'b1}}};
        return s[CW-1:0];
    endfunction

    function automatic logic slt(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Exact unsigned |a-b|.
    function automatic logic [CW:0] adiff(input logic [CW-1:0] a,
                                          input logic [CW-1:0] b);
        logic signed [CW:0] d;
        d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        return d[CW] ? (CW+1)'(-d) : d;
    endfunction

    // a-b when a>=b, else 0.
    function automatic logic [CW:0] pdiff(input logic [CW-1:0] a,
                                          input logic [CW-1:0] b);
        logic signed [CW:0] d;
        d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        return d[CW] ? '0 : d;
    endfunction

endpackage

FILE: sv/aabb_collision_pushout_core.sv
// ============================================================================
// aabb_collision_pushout_core
// Box table collision push-out over a chain of per-box cells.
// ============================================================================
//
// Channel   | Dir | Payload
// s_axis    | in  | tdata: command, box_index, first_x/y/z, second_x/y/z
// m_axis    | out | tdata: pos_x, pos_y, pos_z
// cfg       | in  | write enable, register index, 31-bit data
//
// A box write is stored in its cell and produces no beat. A resolve walks the chain
// one cell per cycle, passing the position register through cells 0 to
// min(active_boxes, MAX_BOXES) - 1 in order, and then shows the result beat.
// The result register holds its beat under m_axis_tready low; a new input is
// taken only after the result beat has left. Reset is synchronous, active low.
//
module aabb_collision_pushout_core #(
    parameter int MAX_BOXES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // low to high: command[0], box_index[4:1], first_x, first_y, first_z,
    // second_x, second_y, second_z, zero fill to 200 bits
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // low to high: pos_x, pos_y, pos_z
    output logic [95:0]  m_axis_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);
    import acp_pkg::*;

    localparam int NW = $clog2(MAX_BOXES + 1);

    logic [30:0]   rad_reg, eye_reg;
    logic [4:0]    act_reg;
    state_t        state_reg, state_next;
    logic [NW-1:0] cnt_reg, cnt_next, n_eff;
    vec_t          old_reg, pos_reg, pos_next;
    logic          accept;
    cmd_t          cmd;
    logic [3:0]    bidx;
    vec_t          fa, fb;
    vec_t          cell_out [MAX_BOXES];

    assign accept = s_axis_tvalid && s_axis_tready;
    assign cmd    = cmd_t'(s_axis_tdata[0]);
    assign bidx   = s_axis_tdata[4:1];
    assign fa     = '{x: s_axis_tdata[36:5], y: s_axis_tdata[68:37],
                      z: s_axis_tdata[100:69]};
    assign fb     = '{x: s_axis_tdata[132:101], y: s_axis_tdata[164:133],
                      z: s_axis_tdata[196:165]};

    // Clamp the active count to the table size.
    assign n_eff = ({27'd0, act_reg} > 32'(MAX_BOXES)) ? NW'(MAX_BOXES)
                                                       : NW'(act_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rad_reg <= 31'd32768;
            eye_reg <= 31'd111411;
            act_reg <= 5'd0;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_RADIUS: rad_reg <= cfg_data;
                REG_EYE:    eye_reg <= cfg_data;
                REG_ACTIVE: act_reg <= cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_BOXES; g++) begin : g_cell
            acp_cell u_cell (
                .aclk    (aclk),
                .wr_en   (accept && cmd == CMD_WRITE &&
                          {28'd0, bidx} == 32'(g)),
                .wr_box  ('{mn: fa, mx: fb}),
                .act     (32'(cnt_reg) == 32'(g)),
                .old_pos (old_reg),
                .rad     ({1'b0, rad_reg}),
                .eye     ({1'b0, eye_reg}),
                .pos_in  (pos_reg),
                .pos_out (cell_out[g])
            );
        end
    endgenerate

    // The active cell drives the next position; inactive cells pass through.
    always_comb begin
        pos_next = pos_reg;
        for (int k = 0; k < MAX_BOXES; k++) begin
            if (32'(cnt_reg) == k) pos_next = cell_out[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Only the first n_eff cells may touch the position; the closing walk
    // cycle just hands over to the output state.
    always_ff @(posedge aclk) begin
        if (accept) begin
            old_reg <= fa;
            pos_reg <= fb;
        end else if (state_reg == ST_WALK && cnt_reg < n_eff) begin
            pos_reg <= pos_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                cnt_next      = '0;
                if (s_axis_tvalid && cmd == CMD_RESOLVE) state_next = ST_WALK;
            end
            ST_WALK: begin
                if (cnt_reg >= n_eff) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_axis_tdata = {pos_reg.z, pos_reg.y, pos_reg.x};

endmodule

FILE: sv/acp_cell.sv
// ============================================================================
// acp_cell
// One table slot: holds a box and applies its push-out to a passing position.
// ============================================================================
module acp_cell (
    input  logic         aclk,
    input  logic         wr_en,
    input  acp_pkg::box_t wr_box,
    input  logic         act,
    input  acp_pkg::vec_t old_pos,
    input  logic [acp_pkg::CW-1:0] rad,
    input  logic [acp_pkg::CW-1:0] eye,
    input  acp_pkg::vec_t pos_in,
    output acp_pkg::vec_t pos_out
);
    import acp_pkg::*;

    box_t box_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            box_reg <= wr_box;
        end
    end

    logic [CW-1:0] mnx, mxx, mnz, mxz, mny, mxy, feet, head, ofeet, ohead;
    logic          hit, ox, oz, oy, ox2, oz2, oy2;
    logic [CW:0]   dx, dz, dy;
    logic [CW:0]   pen [6];
    logic [2:0]    ax;
    vec_t          p;

    always_comb begin
        mnx   = ssub(box_reg.mn.x, rad);
        mxx   = sadd(box_reg.mx.x, rad);
        mnz   = ssub(box_reg.mn.z, rad);
        mxz   = sadd(box_reg.mx.z, rad);
        mny   = box_reg.mn.y;
        mxy   = box_reg.mx.y;
        feet  = ssub(pos_in.y, eye);
        head  = sadd(pos_in.y, HEAD_CLEAR);
        ofeet = ssub(old_pos.y, eye);
        ohead = sadd(old_pos.y, HEAD_CLEAR);
        hit = !(slt(pos_in.x, mnx) || slt(mxx, pos_in.x) ||
                slt(pos_in.z, mnz) || slt(mxz, pos_in.z) ||
                slt(mxy, feet) || slt(head, mny));
        ox = slt(old_pos.x, mnx) || slt(mxx, old_pos.x);
        oz = slt(old_pos.z, mnz) || slt(mxz, old_pos.z);
        oy = slt(mxy, ofeet) || slt(ohead, mny);
        dx = ox ? adiff(pos_in.x, old_pos.x) : '0;
        dz = oz ? adiff(pos_in.z, old_pos.z) : '0;
        dy = oy ? adiff(pos_in.y, old_pos.y) : '0;
        ox2 = ox; oz2 = oz; oy2 = oy;
        if ((ox && oz) || (ox && oy) || (oz && oy)) begin
            if (dx >= dz && dx >= dy) begin
                oz2 = 1'b0; oy2 = 1'b0;
            end else if (dz >= dx && dz >= dy) begin
                ox2 = 1'b0; oy2 = 1'b0;
            end else begin
                ox2 = 1'b0; oz2 = 1'b0;
            end
        end
        pen[0] = pdiff(pos_in.x, mnx);
        pen[1] = pdiff(mxx, pos_in.x);
        pen[2] = pdiff(pos_in.z, mnz);
        pen[3] = pdiff(mxz, pos_in.z);
        pen[4] = pdiff(mxy, feet);
        pen[5] = pdiff(head, mny);
        ax = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (pen[k] < pen[ax]) ax = 3'(k);
        end
        p = pos_in;
        if (act && hit) begin
            if (ox2) begin
                p.x = slt(old_pos.x, mnx) ? mnx : mxx;
            end else if (oz2) begin
                p.z = slt(old_pos.z, mnz) ? mnz : mxz;
            end else if (oy2) begin
                p.y = slt(mxy, ofeet) ? sadd(mxy, eye) : ssub(mny, HEAD_CLEAR);
            end else begin
                case (ax)
                    3'd0:    p.x = mnx;
                    3'd1:    p.x = mxx;
                    3'd2:    p.z = mnz;
                    3'd3:    p.z = mxz;
                    3'd4:    p.y = sadd(mxy, eye);
                    default: p.y = ssub(mny, HEAD_CLEAR);
                endcase
            end
        end
        pos_out = p;
    end

endmodule

FILE: sv/acp_checker.sv
// ============================================================================
// acp_checker
// Port-level checks for the collision push-out core.
// ============================================================================
module acp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    // Input and output are never open in the same cycle.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output both open");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed");

    a_nodup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result repeated");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result after reset");
endmodule

bind aabb_collision_pushout_core acp_checker u_acp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
